// File: hw/rtl/stable_bounded_priority_queue_core_assert.svh
// Assertion macros for the stable bounded priority queue core.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef STABLE_BOUNDED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define STABLE_BOUNDED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define SBPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define SBPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sbpq_pkg.sv
// Package for the stable bounded priority queue core: payload structs,
// status codes, state encoding and controller/datapath command structs.
package sbpq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMPACT
  } state_e;

  // One request
  typedef struct packed {
    logic        mode;
    logic [31:0] job_tag;
    logic [31:0] job_priority;
  } req_t;

  // One result
  typedef struct packed {
    status_e     status;
    logic [31:0] out_tag;
    logic [31:0] out_priority;
    logic [31:0] out_sequence;
  } res_t;

  // One stored job
  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] pri;
    logic [31:0] seq;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic    push_wr;
    logic    pop_start;
    logic    scan_step;
    logic    compact_step;
    logic    pop_finish;
    logic    emit;
    status_e status;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_pop;
    logic pri_zero;
    logic full;
    logic empty;
    logic ptr_end;
  } dp_stat_t;

endpackage

// File: hw/rtl/sbpq_ctrl.sv
// Controller for the priority queue: decodes each request and sequences
// the scan and compaction of a pop. Depends on sbpq_pkg.
module sbpq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  sbpq_pkg::dp_stat_t  stat_i,
  output sbpq_pkg::ctl_cmd_t  cmd_o,
  output logic                busy
);
  import sbpq_pkg::*;

  state_e state_q, state_d;

  // Hold the state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Decide next state and drive datapath commands
  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    cmd_o.status       = ST_OK;
    busy               = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (!stat_i.is_pop) begin
            cmd_o.emit = 1'b1;
            if (stat_i.pri_zero) begin
              cmd_o.status = ST_INVALID;
            end else if (stat_i.full) begin
              cmd_o.status = ST_FULL;
            end else begin
              cmd_o.push_wr = 1'b1;
            end
          end else if (stat_i.empty) begin
            cmd_o.emit   = 1'b1;
            cmd_o.status = ST_EMPTY;
          end else begin
            cmd_o.pop_start = 1'b1;
            state_d         = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.ptr_end) begin
          state_d = S_COMPACT;
        end
      end
      S_COMPACT: begin
        cmd_o.compact_step = 1'b1;
        if (stat_i.ptr_end) begin
          cmd_o.pop_finish = 1'b1;
          cmd_o.emit       = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/sbpq_datapath.sv
// Datapath for the priority queue: job memory, occupancy and sequence
// counters, scan pointer, best-job register and result register.
// Depends on sbpq_pkg.
module sbpq_datapath #(
  parameter int unsigned QueueDepth = sbpq_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbpq_pkg::req_t      req_i,
  input  sbpq_pkg::ctl_cmd_t  cmd_i,
  output sbpq_pkg::dp_stat_t  stat_o,
  output logic                done_o,
  output sbpq_pkg::res_t      res_o
);
  import sbpq_pkg::*;

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(QueueDepth);
  localparam logic [CntW-1:0] OneC   = CntW'(1);
  localparam logic [CntW-1:0] TwoC   = CntW'(2);

  entry_t          mem_q [QueueDepth];
  entry_t          rdata_q;
  entry_t          wr_data;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [IdxW-1:0] rd_addr;

  logic [CntW-1:0] occ_q, occ_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] ptr_m1, ptr_m2;
  logic            wr_pend_q, wr_pend_d;
  logic [31:0]     seq_q, seq_d;
  entry_t          best_q, best_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic            take;
  logic            done_q;
  res_t            res_q, res_d;

  // Report request decode and counter status
  assign stat_o.is_pop   = (req_i.mode == MODE_POP);
  assign stat_o.pri_zero = (req_i.job_priority == 32'd0);
  assign stat_o.full     = (occ_q == DepthC);
  assign stat_o.empty    = (occ_q == '0);
  assign stat_o.ptr_end  = (ptr_q == occ_q);

  assign ptr_m1 = ptr_q - OneC;
  assign ptr_m2 = ptr_q - TwoC;

  // Take the first job scanned; then replace the best job on a strictly lower priority or an earlier tie
  assign take = (ptr_q == OneC)
             || (rdata_q.pri < best_q.pri)
             || ((rdata_q.pri == best_q.pri) && (rdata_q.seq < best_q.seq));

  // Memory port selection
  always_comb begin
    rd_addr = cmd_i.pop_start ? '0 : ptr_q[IdxW-1:0];
    wr_en   = 1'b0;
    wr_addr = occ_q[IdxW-1:0];
    wr_data = rdata_q;
    if (cmd_i.push_wr) begin
      wr_en   = 1'b1;
      wr_data = '{tag: req_i.job_tag, pri: req_i.job_priority, seq: seq_q};
    end else if (cmd_i.compact_step && wr_pend_q) begin
      wr_en   = 1'b1;
      wr_addr = ptr_m2[IdxW-1:0];
    end
  end

  // Job memory with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Advance counters, pointer and best-job tracking
  always_comb begin
    occ_d      = occ_q;
    seq_d      = seq_q;
    ptr_d      = ptr_q;
    wr_pend_d  = wr_pend_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    if (cmd_i.push_wr) begin
      occ_d = occ_q + OneC;
      seq_d = seq_q + 32'd1;
    end
    if (cmd_i.pop_start) begin
      ptr_d = OneC;
    end
    if (cmd_i.scan_step) begin
      if (take) begin
        best_d     = rdata_q;
        best_idx_d = ptr_m1[IdxW-1:0];
      end
      if (stat_o.ptr_end) begin
        ptr_d     = CntW'(best_idx_d) + OneC;
        wr_pend_d = 1'b0;
      end else begin
        ptr_d = ptr_q + OneC;
      end
    end
    if (cmd_i.compact_step && !stat_o.ptr_end) begin
      ptr_d     = ptr_q + OneC;
      wr_pend_d = 1'b1;
    end
    if (cmd_i.pop_finish) begin
      occ_d = occ_q - OneC;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= '0;
      seq_q     <= 32'd1;
      ptr_q     <= '0;
      wr_pend_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      occ_q     <= occ_d;
      seq_q     <= seq_d;
      ptr_q     <= ptr_d;
      wr_pend_q <= wr_pend_d;
      done_q    <= cmd_i.emit;
    end
  end

  // Build the result; job fields only on a successful pop
  always_comb begin
    res_d        = res_q;
    if (cmd_i.emit) begin
      res_d.status       = cmd_i.status;
      res_d.out_tag      = cmd_i.pop_finish ? best_q.tag : 32'd0;
      res_d.out_priority = cmd_i.pop_finish ? best_q.pri : 32'd0;
      res_d.out_sequence = cmd_i.pop_finish ? best_q.seq : 32'd0;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    res_q      <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: hw/rtl/stable_bounded_priority_queue_core.sv
// Stable bounded min-priority queue of jobs: top level joining the
// controller and datapath. Depends on sbpq_pkg, sbpq_ctrl, sbpq_datapath.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   request  | start, busy          | req_i  (mode, job_tag, job_priority)
//   result   | done_o (one cycle)   | res_o  (status, out_tag, out_priority,
//            |                      |         out_sequence)
//
// A push, a refused push and a pop from an empty queue stay in idle: the
// result strobes in the cycle after the request and busy stays low.
// A pop scans through the single read port of the job memory, one entry
// per cycle, then runs a compaction moving one entry per cycle.
// Reset clears the occupancy and restarts sequence numbers at one; no
// memory clearing is needed. The result receiver cannot stall the block.
module stable_bounded_priority_queue_core #(
  parameter int unsigned QueueDepth = sbpq_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  sbpq_pkg::req_t  req_i,
  output logic            done_o,
  output sbpq_pkg::res_t  res_o
);
  import sbpq_pkg::*;

  `include "stable_bounded_priority_queue_core_assert.svh"

  ctl_cmd_t cmd;
  dp_stat_t stat;

  sbpq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  sbpq_datapath #(
    .QueueDepth (QueueDepth)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // An accepted request either answers at once or keeps the block busy
  `SBPQ_ASSERT_NEXT(a_accept_progress, start && !busy, done_o || busy, "request lost")
  // A result is only given as the block returns to idle
  `SBPQ_ASSERT_NOW(a_done_idle, done_o, !busy, "result while busy")
  // A pop on an empty queue reports empty in the next cycle
  `SBPQ_ASSERT_NEXT(a_pop_empty, start && !busy && stat.is_pop && stat.empty,
                    done_o && (res_o.status == ST_EMPTY), "empty pop not reported")

endmodule
